// File: src/path_point_interpolator_defines.svh
// Assertion macros for the path point interpolator checker.
// Used by ppi_checker.sv only.
`ifndef PATH_POINT_INTERPOLATOR_DEFINES_SVH
`define PATH_POINT_INTERPOLATOR_DEFINES_SVH

// Plain implication checked at every rising edge outside reset
`define PPI_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal must hold in the next cycle when cond is true
`define PPI_ASSERT_HOLD(name, clk, rst_n, cond, sig, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
		else $error(msg);

`endif

// File: src/ppi_pkg.sv
// Shared types and constants for the path point interpolator.
// No dependencies.
`default_nettype none
package ppi_pkg;
	localparam int DW     = 34;   // signed width of anchor values and differences
	localparam int NUM_F  = 5;    // interpolated fields
	localparam int F_X    = 0;
	localparam int F_Y    = 1;
	localparam int F_HDG  = 2;
	localparam int F_CRV  = 3;
	localparam int F_RATE = 4;

	// One interpolation job, low end and high-minus-low per field
	typedef struct packed {
		logic [NUM_F-1:0][DW-1:0] lo;
		logic [NUM_F-1:0][DW-1:0] diff;
		logic signed [32:0]       num;    // query minus low arc
		logic [31:0]              den;    // high arc minus low arc
		logic                     eq;     // arcs equal
		logic [31:0]              arc;    // query arc
	} job_t;
endpackage
`default_nettype wire

// File: src/path_point_interpolator.sv
// Path point interpolator top level: front end, job queue, back end.
// Depends on ppi_pkg, ppi_front, ppi_fifo, ppi_back.
//
// Usage:
//  Input channel (in_valid/in_stall) carries one point per transfer. op 0 stores
//  the point as the anchor and gives no result; op 1 interpolates between the
//  anchor and the point at query_arc and gives one result on the output
//  channel (out_valid/out_stall).
//  Op 0 transfers are written straight into the anchor registers. An op 1 job
//  waits in a two-entry queue, then the back end runs a restoring divider for
//  the weight, one quotient bit per cycle for WEIGHT_FRAC_BITS + 5 quotient
//  bits, then one shared multiplier handles the five fields. The divide is
//  skipped when both arcs are equal or the weight saturates before it. The
//  back end works on one job at a time while the queue takes further op 1
//  jobs; in_stall rises only when the queue is full.
//  A result stays on the output register while out_stall is high; the back
//  end finishes its next job meanwhile and waits for the register to free.
//  Reset clears the anchor to all zeros and empties queue and output.
`default_nettype none
module path_point_interpolator #(
	parameter int ANGLE_BITS       = 16,
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 op,
	input  logic signed [31:0]   point_x,
	input  logic signed [31:0]   point_y,
	input  logic signed [15:0]   point_heading,
	input  logic signed [31:0]   point_curvature,
	input  logic signed [31:0]   point_curvature_rate,
	input  logic signed [31:0]   point_arc,
	input  logic signed [31:0]   query_arc,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [31:0]   out_x,
	output logic signed [31:0]   out_y,
	output logic signed [15:0]   out_heading,
	output logic signed [31:0]   out_curvature,
	output logic signed [31:0]   out_curvature_rate,
	output logic signed [31:0]   out_arc,
	output logic                 weight_clipped
);
	import ppi_pkg::*;

	logic  push, pop, full, empty;
	job_t  wr_job, rd_job;

	assign in_stall = full;

	ppi_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_valid             (in_valid),
		.full                 (full),
		.op                   (op),
		.point_x              (point_x),
		.point_y              (point_y),
		.point_heading        (point_heading),
		.point_curvature      (point_curvature),
		.point_curvature_rate (point_curvature_rate),
		.point_arc            (point_arc),
		.query_arc            (query_arc),
		.push                 (push),
		.job                  (wr_job)
	);

	ppi_fifo #(.WIDTH($bits(job_t)), .DEPTH(2)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_job),
		.pop     (pop),
		.rd_data (rd_job),
		.full    (full),
		.empty   (empty)
	);

	ppi_back #(.ANGLE_BITS(ANGLE_BITS), .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.empty              (empty),
		.rd_job             (rd_job),
		.pop                (pop),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.out_x              (out_x),
		.out_y              (out_y),
		.out_heading        (out_heading),
		.out_curvature      (out_curvature),
		.out_curvature_rate (out_curvature_rate),
		.out_arc            (out_arc),
		.weight_clipped     (weight_clipped)
	);
endmodule
`default_nettype wire

// File: src/ppi_front.sv
// Front end: takes input transfers, keeps the anchor point, orders ends, builds jobs.
// Depends on ppi_pkg.
`default_nettype none
module ppi_front #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 full,
	input  logic                 op,
	input  logic signed [31:0]   point_x,
	input  logic signed [31:0]   point_y,
	input  logic signed [15:0]   point_heading,
	input  logic signed [31:0]   point_curvature,
	input  logic signed [31:0]   point_curvature_rate,
	input  logic signed [31:0]   point_arc,
	input  logic signed [31:0]   query_arc,
	output logic                 push,
	output ppi_pkg::job_t        job
);
	import ppi_pkg::*;
	localparam int AW = ANGLE_BITS;

	logic signed [31:0] anc_x_q, anc_y_q, anc_crv_q, anc_rate_q, anc_arc_q;
	logic signed [15:0] anc_hdg_q;
	logic               acc, swap;
	logic signed [31:0] lo_x, hi_x, lo_y, hi_y, lo_c, hi_c, lo_r, hi_r, lo_a, hi_a;
	logic signed [15:0] lo_h, hi_h;
	logic signed [AW-1:0] h_lo, h_hi, h_d;
	logic signed [AW:0]   h_dx;

	assign acc  = in_valid && !full;
	assign push = acc && op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anc_x_q    <= '0;
			anc_y_q    <= '0;
			anc_hdg_q  <= '0;
			anc_crv_q  <= '0;
			anc_rate_q <= '0;
			anc_arc_q  <= '0;
		end else if (acc && !op) begin
			anc_x_q    <= point_x;
			anc_y_q    <= point_y;
			anc_hdg_q  <= point_heading;
			anc_crv_q  <= point_curvature;
			anc_rate_q <= point_curvature_rate;
			anc_arc_q  <= point_arc;
		end
	end

	// incoming point is the low end only when the anchor lies further along
	assign swap = anc_arc_q > point_arc;

	always_comb begin
		lo_x = swap ? point_x : anc_x_q;              hi_x = swap ? anc_x_q : point_x;
		lo_y = swap ? point_y : anc_y_q;              hi_y = swap ? anc_y_q : point_y;
		lo_h = swap ? point_heading : anc_hdg_q;      hi_h = swap ? anc_hdg_q : point_heading;
		lo_c = swap ? point_curvature : anc_crv_q;    hi_c = swap ? anc_crv_q : point_curvature;
		lo_r = swap ? point_curvature_rate : anc_rate_q;
		hi_r = swap ? anc_rate_q : point_curvature_rate;
		lo_a = swap ? point_arc : anc_arc_q;          hi_a = swap ? anc_arc_q : point_arc;

		h_lo = AW'(lo_h);
		h_hi = AW'(hi_h);
		h_d  = h_hi - h_lo;
		// minus half turn maps to plus half turn
		h_dx = (h_d == {1'b1, {(AW-1){1'b0}}}) ? {2'b01, {(AW-1){1'b0}}} : (AW+1)'(h_d);

		job.lo[F_X]      = DW'(lo_x);
		job.lo[F_Y]      = DW'(lo_y);
		job.lo[F_HDG]    = DW'(h_lo);
		job.lo[F_CRV]    = DW'(lo_c);
		job.lo[F_RATE]   = DW'(lo_r);
		job.diff[F_X]    = DW'(hi_x) - DW'(lo_x);
		job.diff[F_Y]    = DW'(hi_y) - DW'(lo_y);
		job.diff[F_HDG]  = DW'(h_dx);
		job.diff[F_CRV]  = DW'(hi_c) - DW'(lo_c);
		job.diff[F_RATE] = DW'(hi_r) - DW'(lo_r);
		job.num          = 33'(query_arc) - 33'(lo_a);
		job.den          = 32'(33'(hi_a) - 33'(lo_a));
		job.eq           = hi_a == lo_a;
		job.arc          = query_arc;
	end
endmodule
`default_nettype wire

// File: src/ppi_fifo.sv
// Small register queue between front and back end.
// No dependencies.
`default_nettype none
module ppi_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int AWD = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW  = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AWD-1:0]   wp_q, rp_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = cnt_q == CW'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == AWD'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == AWD'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
		end
	end
endmodule
`default_nettype wire

// File: src/ppi_back.sv
// Back end: restoring divider for the weight, shared multiplier for the five
// fields, rounding, saturation and the output register. Depends on ppi_pkg.
`default_nettype none
module ppi_back #(
	parameter int ANGLE_BITS       = 16,
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 empty,
	input  ppi_pkg::job_t        rd_job,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [31:0]   out_x,
	output logic signed [31:0]   out_y,
	output logic signed [15:0]   out_heading,
	output logic signed [31:0]   out_curvature,
	output logic signed [31:0]   out_curvature_rate,
	output logic signed [31:0]   out_arc,
	output logic                 weight_clipped
);
	import ppi_pkg::*;
	localparam int F   = WEIGHT_FRAC_BITS;
	localparam int AW  = ANGLE_BITS;
	localparam int QB  = F + 5;          // quotient bits, covers 8.0 and overflow
	localparam int WW  = QB + 1;         // signed weight
	localparam int NW  = 34 + F;         // rounded dividend
	localparam int TW  = NW - QB;
	localparam int PW  = DW + WW;
	localparam int CW  = $clog2(QB + 1);
	localparam logic [QB-1:0]     WMAX = QB'(8) << F;
	localparam logic signed [WW-1:0] ONE = WW'(1) << F;
	localparam logic signed [PW:0]   RND = (PW+1)'(1) << (F - 1);
	localparam logic signed [PW+1:0] SMAX = (PW+2)'(32'sh7fffffff);
	localparam logic signed [PW+1:0] SMIN = -(PW+2)'(33'sh080000000);

	typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_WGT, ST_MUL, ST_FIN} state_t;

	state_t             state_q;
	job_t               job_q;
	logic               neg_q, clip_q, pv_s1;
	logic [CW-1:0]      cnt_q;
	logic [31:0]        rem_q;
	logic [QB-1:0]      nlo_q, qt_q;
	logic signed [WW-1:0] w_q;
	logic signed [PW-1:0] prod_s1;
	logic [2:0]         pidx_s1;
	logic [31:0]        res_q [NUM_F];
	logic               out_valid_q;
	logic [31:0]        ox_q, oy_q, oc_q, or_q, oa_q;
	logic [15:0]        oh_q;
	logic               oclip_q;

	// divider start, from the queue head
	logic               s_neg, s_big;
	logic [32:0]        s_abs;
	logic [NW-1:0]      s_n;
	logic [TW-1:0]      s_top;
	// divider step
	logic [32:0]        trial;
	logic               ge;
	// weight
	logic [QB-1:0]      mag;
	// multiply and finish
	logic signed [DW-1:0] dsel, lsel;
	logic signed [PW:0]   rsum, scl;
	logic signed [PW+1:0] res;
	logic signed [AW-1:0] hw;
	logic [31:0]          fin;
	logic                 load;

	assign pop  = (state_q == ST_IDLE) && !empty;
	assign load = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	always_comb begin
		s_neg = rd_job.num[32];
		s_abs = s_neg ? 33'(-rd_job.num) : 33'(rd_job.num);
		s_n   = NW'({s_abs, {F{1'b0}}}) + NW'(rd_job.den >> 1);
		s_top = s_n[NW-1:QB];
		s_big = 33'(s_top) >= 33'(rd_job.den);

		trial = {rem_q, nlo_q[QB-1]};
		ge    = trial >= {1'b0, job_q.den};

		mag = (qt_q > WMAX) ? WMAX : qt_q;

		dsel = $signed(job_q.diff[cnt_q[2:0]]);
		lsel = $signed(job_q.lo[pidx_s1]);
		rsum = (PW+1)'(prod_s1) + RND;
		scl  = rsum >>> F;
		res  = (PW+2)'(scl) + (PW+2)'(lsel);
		hw   = AW'(res);
		if (pidx_s1 == 3'(F_HDG)) begin
			fin = 32'(16'(hw));
		end else if (res > SMAX) begin
			fin = 32'h7fffffff;
		end else if (res < SMIN) begin
			fin = 32'h80000000;
		end else begin
			fin = 32'(res);
		end
	end

	always_ff @(posedge clk) begin
		if (pv_s1) begin
			res_q[pidx_s1] <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_q       <= '0;
			neg_q       <= 1'b0;
			clip_q      <= 1'b0;
			cnt_q       <= '0;
			rem_q       <= '0;
			nlo_q       <= '0;
			qt_q        <= '0;
			w_q         <= '0;
			prod_s1     <= '0;
			pidx_s1     <= '0;
			pv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
			ox_q        <= '0;
			oy_q        <= '0;
			oh_q        <= '0;
			oc_q        <= '0;
			or_q        <= '0;
			oa_q        <= '0;
			oclip_q     <= 1'b0;
		end else begin
			pv_s1 <= 1'b0;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						job_q <= rd_job;
						neg_q <= s_neg;
						cnt_q <= '0;
						qt_q  <= '0;
						if (rd_job.eq) begin
							w_q     <= ONE;
							clip_q  <= 1'b0;
							state_q <= ST_MUL;
						end else if (s_big) begin
							w_q     <= s_neg ? -WW'({1'b0, WMAX}) : WW'({1'b0, WMAX});
							clip_q  <= 1'b1;
							state_q <= ST_MUL;
						end else begin
							rem_q   <= 32'(s_top);
							nlo_q   <= s_n[QB-1:0];
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					rem_q <= ge ? 32'(trial - {1'b0, job_q.den}) : 32'(trial);
					nlo_q <= nlo_q << 1;
					qt_q  <= {qt_q[QB-2:0], ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(QB - 1)) begin
						state_q <= ST_WGT;
					end
				end
				ST_WGT: begin
					clip_q  <= qt_q > WMAX;
					w_q     <= neg_q ? -WW'({1'b0, mag}) : WW'({1'b0, mag});
					cnt_q   <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					// one field per cycle, finish lags multiply by one stage
					if (cnt_q < CW'(NUM_F)) begin
						prod_s1 <= w_q * dsel;
						pidx_s1 <= cnt_q[2:0];
						pv_s1   <= 1'b1;
						cnt_q   <= cnt_q + 1'b1;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (load) begin
						ox_q    <= res_q[F_X];
						oy_q    <= res_q[F_Y];
						oh_q    <= res_q[F_HDG][15:0];
						oc_q    <= res_q[F_CRV];
						or_q    <= res_q[F_RATE];
						oa_q    <= job_q.arc;
						oclip_q <= clip_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid          = out_valid_q;
	assign out_x              = ox_q;
	assign out_y              = oy_q;
	assign out_heading        = oh_q;
	assign out_curvature      = oc_q;
	assign out_curvature_rate = or_q;
	assign out_arc            = oa_q;
	assign weight_clipped     = oclip_q;
endmodule
`default_nettype wire

// File: src/ppi_checker.sv
// Port-level checks for the path point interpolator, bound to the top level.
// Depends on path_point_interpolator_defines.svh.
`default_nettype none
`include "path_point_interpolator_defines.svh"
module ppi_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] out_arc,
	input logic signed [15:0] out_heading
);
	`PPI_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid, "stalled result dropped")
	`PPI_ASSERT_HOLD(a_out_stable, clk, arst_n, out_valid && out_stall, out_arc, "stalled result changed")
	`PPI_ASSERT_HOLD(a_hdg_stable, clk, arst_n, out_valid && out_stall, out_heading, "stalled heading changed")
	// queue and output register come out of reset empty
	`PPI_ASSERT(a_rst_out, clk, arst_n, $rose(arst_n) |-> !out_valid, "result right after reset")
	`PPI_ASSERT(a_rst_in, clk, arst_n, $rose(arst_n) |-> !in_stall, "input blocked after reset")
endmodule

bind path_point_interpolator ppi_checker u_ppi_checker (.*);
`default_nettype wire
